### hdl/twq_pkg.sv
// ----------------------------------------------------------------------------
// twq_pkg: shared types for the timed wait queue
// Item formats, operation and release codes, and the command and status
// structs between the queue controller and the output stage.
// ----------------------------------------------------------------------------
package twq_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_DEQ     = 2'd0,
    KIND_TIMEOUT = 2'd1,
    KIND_FLUSH   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    func_t       func;
    logic [7:0]  thread_id;
    logic [15:0] wait_ticks;
  } in_item_t;

  typedef struct packed {
    logic [7:0] released_id;
    kind_t      kind;
    logic       raise_count;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // push: hand over a result; fin: this closes the current input item
  typedef struct packed {
    logic      push;
    logic      fin;
    out_item_t res;
  } ostage_cmd_t;

  typedef struct packed {
    logic ok;      // output register free for a new result this cycle
    logic pend_v;  // a result is held back awaiting its last flag
  } ostage_stat_t;

  function automatic out_item_t mk_res(input logic [7:0] id, input kind_t k,
                                       input logic raise, input logic [1:0] st);
    out_item_t r;
    r.released_id = id;
    r.kind        = k;
    r.raise_count = raise;
    r.status      = st;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

### hdl/twq_ostage.sv
// ----------------------------------------------------------------------------
// twq_ostage: result output stage
// Holds one result back until it is known whether it is the final one of
// its item, then moves it into the output register that drives the port.
// ----------------------------------------------------------------------------
module twq_ostage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  twq_pkg::ostage_cmd_t  cmd,
  output twq_pkg::ostage_stat_t stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output twq_pkg::out_item_t    out_item
);
  import twq_pkg::*;

  logic      out_v_r, out_v_nxt;
  out_item_t out_r, out_nxt;
  logic      pend_v_r, pend_v_nxt;
  out_item_t pend_r, pend_nxt;
  logic      ok;

  assign ok          = !out_v_r || out_ready;
  assign stat.ok     = ok;
  assign stat.pend_v = pend_v_r;
  assign out_valid   = out_v_r;
  assign out_item    = out_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    if (out_v_r && out_ready) begin
      out_v_nxt = 1'b0;
    end
    if (cmd.push && !cmd.fin) begin
      // advance the held result, keep the new one back
      if (pend_v_r) begin
        out_nxt      = pend_r;
        out_nxt.last = 1'b0;
        out_v_nxt    = 1'b1;
      end
      pend_nxt   = cmd.res;
      pend_v_nxt = 1'b1;
    end else if (cmd.push && cmd.fin) begin
      out_nxt      = cmd.res;
      out_nxt.last = 1'b1;
      out_v_nxt    = 1'b1;
    end else if (cmd.fin) begin
      out_nxt      = pend_r;
      out_nxt.last = 1'b1;
      out_v_nxt    = 1'b1;
      pend_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      pend_v_r <= pend_v_nxt;
    end
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  // a closing push never meets a held result
  a_fin_push_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && cmd.fin) |-> !pend_v_r)
    else $error("closing push while a result is held");

  // a bare close always has a held result to release
  a_fin_has_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin && !cmd.push) |-> pend_v_r)
    else $error("close without held result");

  // anything that lands in the output register finds it free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin || (cmd.push && pend_v_r)) |-> ok)
    else $error("output register overwritten");

endmodule

### hdl/twq_ctrl.sv
// ----------------------------------------------------------------------------
// twq_ctrl: queue controller and entry memory
// Circular buffer of {thread id, wait count} in a synchronous memory. Ticks and
// clears walk the live entries one per cycle unless a release waits for room, compacting survivors.
// ----------------------------------------------------------------------------
module twq_ctrl #(
  parameter int DEPTH     = 16,
  parameter int WAIT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  twq_pkg::in_item_t     in_item,
  output twq_pkg::ostage_cmd_t  cmd,
  input  twq_pkg::ostage_stat_t stat
);
  import twq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = 8 + WAIT_BITS;

  typedef enum logic [1:0] {S_IDLE, S_RDH, S_WALK, S_FIN} state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   keep_r, keep_nxt;
  func_t           op_r, op_nxt;

  logic [EW-1:0]   mem [DEPTH];
  logic [EW-1:0]   rd_q_r;
  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  logic [EW-1:0]   wdata;

  logic [31:0]          wt_ext;
  logic [WAIT_BITS-1:0] wt;
  logic [7:0]           rd_thread;
  logic [WAIT_BITS-1:0] rd_wait;
  logic                 emit, last_ent;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign wt_ext    = 32'(in_item.wait_ticks);
  assign wt        = wt_ext[WAIT_BITS-1:0];
  assign rd_thread = rd_q_r[EW-1 -: 8];
  assign rd_wait   = rd_q_r[WAIT_BITS-1:0];
  assign emit      = (op_r == FUNC_CLEAR) || (rd_wait == WAIT_BITS'(1));
  assign last_ent  = ({1'b0, idx_r} == (AW+1)'(cnt_r - CW'(1)));
  assign in_ready  = (state_r == S_IDLE) && stat.ok;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    head_nxt  = head_r;
    idx_nxt   = idx_r;
    keep_nxt  = keep_r;
    op_nxt    = op_r;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    re        = 1'b0;
    raddr     = head_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.res = mk_res(8'd0, KIND_NONE, 1'b0, ST_OK);
          unique case (in_item.func)
            FUNC_ADD: begin
              cmd.push = 1'b1;
              cmd.fin  = 1'b1;
              if (cnt_r == CW'(DEPTH)) begin
                cmd.res.status = ST_FULL;
              end else begin
                we      = 1'b1;
                waddr   = wrap(head_r, cnt_r[AW-1:0]);
                wdata   = {in_item.thread_id, wt};
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            FUNC_REMOVE: begin
              if (cnt_r == '0) begin
                cmd.push       = 1'b1;
                cmd.fin        = 1'b1;
                cmd.res.status = ST_EMPTY;
              end else begin
                re        = 1'b1;
                state_nxt = S_RDH;
              end
            end
            FUNC_TICK, FUNC_CLEAR: begin
              if (cnt_r == '0) begin
                cmd.push = 1'b1;
                cmd.fin  = 1'b1;
              end else begin
                re        = 1'b1;
                idx_nxt   = '0;
                keep_nxt  = '0;
                op_nxt    = in_item.func;
                state_nxt = S_WALK;
              end
            end
          endcase
        end
      end
      S_RDH: begin
        if (stat.ok) begin
          cmd.push  = 1'b1;
          cmd.fin   = 1'b1;
          cmd.res   = mk_res(rd_thread, KIND_DEQ, 1'b0, ST_OK);
          head_nxt  = wrap(head_r, AW'(1));
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_IDLE;
        end
      end
      S_WALK: begin
        // hold the entry while a release cannot be handed over
        if (!emit || stat.ok) begin
          if (emit) begin
            cmd.push = 1'b1;
            if (op_r == FUNC_CLEAR) begin
              cmd.res = mk_res(rd_thread, KIND_FLUSH, 1'b0, ST_OK);
            end else begin
              cmd.res = mk_res(rd_thread, KIND_TIMEOUT, 1'b1, ST_OK);
            end
          end else begin
            // compact the survivor down to the next kept slot
            we       = 1'b1;
            waddr    = wrap(head_r, keep_r[AW-1:0]);
            wdata    = {rd_thread,
                        (rd_wait > WAIT_BITS'(1)) ? rd_wait - WAIT_BITS'(1) : rd_wait};
            keep_nxt = keep_r + CW'(1);
          end
          if (last_ent) begin
            state_nxt = S_FIN;
          end else begin
            re      = 1'b1;
            raddr   = wrap(head_r, idx_r + AW'(1));
            idx_nxt = idx_r + AW'(1);
          end
        end
      end
      S_FIN: begin
        if (stat.ok) begin
          cmd.fin = 1'b1;
          if (!stat.pend_v) begin
            cmd.push = 1'b1;
            cmd.res  = mk_res(8'd0, KIND_NONE, 1'b0, ST_OK);
          end
          cnt_nxt   = (op_r == FUNC_TICK) ? keep_r : '0;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      head_r  <= '0;
      idx_r   <= '0;
      keep_r  <= '0;
      op_r    <= FUNC_ADD;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      head_r  <= head_nxt;
      idx_r   <= idx_nxt;
      keep_r  <= keep_nxt;
      op_r    <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q_r <= mem[raddr];
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK || state_r == S_RDH) |-> (cnt_r != '0))
    else $error("walking an empty queue");

  a_keep_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> ({1'b0, keep_r} <= (CW+1)'(idx_r)))
    else $error("compaction write overtook the read");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_item.func == FUNC_ADD && cnt_r != CW'(DEPTH))
      |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("add did not grow the queue");

endmodule

### hdl/timed_wait_queue_core.sv
// ----------------------------------------------------------------------------
// timed_wait_queue_core: FIFO of waiting thread ids with timeouts
// Add, remove, tick and clear on one input channel; releases on the
// result channel, one or more per item, the final one flagged last.
// ----------------------------------------------------------------------------
// Use: present an item on in_valid/in_item; it is taken when in_ready is
// high. Results leave on out_valid/out_item and are taken with out_ready.
// Entries sit in a circular buffer in one synchronous memory (one read,
// one write port, registered read data).
// Add, a full add, an empty remove and operations on an empty queue hand
// their result to the output stage on acceptance; a remove first reads the
// memory in S_RDH. A tick or clear walks its entries one per cycle in
// S_WALK, holding while a release has no room, and closes in S_FIN.
// One item is in work at a time; in_ready rises again once its last result
// is handed to the output register.
// Reset empties the queue; entry contents are not cleared and need no pass.
// A stalled receiver holds the walk whenever a release has no room, and
// never loses or repeats a result.
// ----------------------------------------------------------------------------
module timed_wait_queue_core #(
  parameter int DEPTH     = 16,
  parameter int WAIT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  twq_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output twq_pkg::out_item_t out_item
);
  import twq_pkg::*;

  ostage_cmd_t  cmd;
  ostage_stat_t stat;

  twq_ctrl #(
    .DEPTH     (DEPTH),
    .WAIT_BITS (WAIT_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat)
  );

  twq_ostage u_ostage (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for timed_wait_queue_core
// Drives adds, removes, ticks and clears through the valid/ready input
// channel. An in-bench model of the waiting queue predicts every release,
// and each result taken from the output channel is checked against it.
// The sender runs in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
import twq_pkg::*;

localparam int QUEUE_DEPTH = 16;

class release_scoreboard;
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] ticks;
  } waiter_t;

  waiter_t   waiters[$];
  out_item_t due[$];
  int        errors;
  int        n_func[4];
  int        n_deq, n_timeout, n_flush, n_full, n_empty, peak;

  function out_item_t release_of(logic [7:0] id, kind_t k, logic raise,
                                 logic [1:0] st);
    out_item_t r;
    r.released_id = id;
    r.kind        = k;
    r.raise_count = raise;
    r.status      = st;
    r.last        = 1'b0;
    return r;
  endfunction

  // apply one accepted item to the queue and queue up its releases
  function void note_item(in_item_t it);
    out_item_t batch[$];
    waiter_t   kept[$];
    waiter_t   w;
    n_func[it.func]++;
    case (it.func)
      FUNC_ADD: begin
        if (waiters.size() >= QUEUE_DEPTH) begin
          batch.push_back(release_of(8'd0, KIND_NONE, 1'b0, ST_FULL));
          n_full++;
        end else begin
          w.id    = it.thread_id;
          w.ticks = it.wait_ticks;
          waiters.push_back(w);
          batch.push_back(release_of(8'd0, KIND_NONE, 1'b0, ST_OK));
        end
      end
      FUNC_REMOVE: begin
        if (waiters.size() == 0) begin
          batch.push_back(release_of(8'd0, KIND_NONE, 1'b0, ST_EMPTY));
          n_empty++;
        end else begin
          w = waiters.pop_front();
          batch.push_back(release_of(w.id, KIND_DEQ, 1'b0, ST_OK));
          n_deq++;
        end
      end
      FUNC_TICK: begin
        foreach (waiters[i]) begin
          w = waiters[i];
          if (w.ticks == 16'd1) begin
            batch.push_back(release_of(w.id, KIND_TIMEOUT, 1'b1, ST_OK));
            n_timeout++;
          end else begin
            // zero means wait forever: keep it untouched
            if (w.ticks > 16'd1) w.ticks = w.ticks - 16'd1;
            kept.push_back(w);
          end
        end
        waiters = kept;
        if (batch.size() == 0)
          batch.push_back(release_of(8'd0, KIND_NONE, 1'b0, ST_OK));
      end
      default: begin
        foreach (waiters[i]) begin
          batch.push_back(release_of(waiters[i].id, KIND_FLUSH, 1'b0, ST_OK));
          n_flush++;
        end
        waiters.delete();
        if (batch.size() == 0)
          batch.push_back(release_of(8'd0, KIND_NONE, 1'b0, ST_OK));
      end
    endcase
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) due.push_back(batch[i]);
    if (waiters.size() > peak) peak = waiters.size();
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (due.size() == 0) begin
      errors++;
      $error("unexpected result: released_id %0d kind %0d status %0d",
             got.released_id, got.kind, got.status);
      return;
    end
    want = due.pop_front();
    if (got.released_id !== want.released_id) begin
      errors++;
      $error("released_id: expected %0d, got %0d", want.released_id, got.released_id);
    end
    if (got.kind !== want.kind) begin
      errors++;
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
    end
    if (got.raise_count !== want.raise_count) begin
      errors++;
      $error("raise_count: expected %0d, got %0d", want.raise_count, got.raise_count);
    end
    if (got.status !== want.status) begin
      errors++;
      $error("status: expected %0d, got %0d", want.status, got.status);
    end
    if (got.last !== want.last) begin
      errors++;
      $error("last: expected %0d, got %0d", want.last, got.last);
    end
  endfunction
endclass

module tb;
  localparam int N_RANDOM     = 200;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 4000;
  localparam int MODE_FILL    = 0;
  localparam int MODE_GROW    = 1;
  localparam int MODE_DRAIN   = 2;
  localparam int MODE_TIMEOUT = 3;
  localparam int MODE_MIX     = 4;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  release_scoreboard sb = new;
  int burst_left = 0;
  int n_sent = 0;
  bit random_phase = 1'b0;

  timed_wait_queue_core #(
    .DEPTH    (QUEUE_DEPTH),
    .WAIT_BITS(16)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_item_t op_item(func_t f, logic [7:0] id, logic [15:0] t);
    in_item_t it;
    it.func       = f;
    it.thread_id  = id;
    it.wait_ticks = t;
    return it;
  endfunction

  function automatic in_item_t random_op(int mode);
    int       roll;
    func_t    f;
    in_item_t it;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:    f = FUNC_ADD;
      MODE_GROW:    f = (roll < 75) ? FUNC_ADD : (roll < 85) ? FUNC_REMOVE : FUNC_TICK;
      MODE_DRAIN:   f = (roll < 50) ? FUNC_REMOVE : (roll < 80) ? FUNC_TICK :
                        (roll < 95) ? FUNC_ADD : FUNC_CLEAR;
      MODE_TIMEOUT: f = (roll < 50) ? FUNC_TICK : (roll < 90) ? FUNC_ADD : FUNC_REMOVE;
      default:      f = (roll < 30) ? FUNC_ADD : (roll < 55) ? FUNC_REMOVE :
                        (roll < 88) ? FUNC_TICK : FUNC_CLEAR;
    endcase
    it.func      = f;
    it.thread_id = 8'($urandom_range(0, 255));
    // mostly short timeouts so ticks release often
    roll = $urandom_range(0, 9);
    if (roll < 2)      it.wait_ticks = 16'd0;
    else if (roll < 7) it.wait_ticks = 16'($urandom_range(1, 4));
    else if (roll < 8) it.wait_ticks = 16'($urandom_range(5, 24));
    else if (roll < 9) it.wait_ticks = 16'($urandom);
    else               it.wait_ticks = 16'hFFFF - 16'($urandom_range(0, 1));
    return it;
  endfunction

  // offer one item, opening a new burst when due, mostly after a random gap
  task automatic offer(input in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    n_sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_item);
  end

  // receiver: stretches of steady, patchy and blocked readiness
  initial begin
    int  run;
    int  pick;
    bit  held;
    held = 1'b0;
    out_ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (random_phase && !held) begin
        // long hold-off so the sender backs up against a full pipeline
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pick = $urandom_range(0, 9);
      run  = $urandom_range(4, 40);
      repeat (run) begin
        if (pick < 4)      out_ready <= 1'b1;
        else if (pick < 7) out_ready <= 1'($urandom_range(0, 1));
        else if (pick < 9) out_ready <= ($urandom_range(0, 3) == 0);
        else               out_ready <= 1'b0;
        @(posedge clk);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("timed_wait_queue_core: mismatch");
    $finish;
  end

  initial begin
    int mode;
    int seg;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty-queue cases
    offer(op_item(FUNC_REMOVE, 8'hFF, 16'hFFFF));
    offer(op_item(FUNC_TICK,   8'h00, 16'h0000));
    offer(op_item(FUNC_CLEAR,  8'h12, 16'h0001));
    // extremes of id and timeout, plus a wait-forever entry
    offer(op_item(FUNC_ADD, 8'hFF, 16'h0001));
    offer(op_item(FUNC_ADD, 8'h00, 16'h0000));
    offer(op_item(FUNC_ADD, 8'hA5, 16'h0002));
    offer(op_item(FUNC_ADD, 8'h5A, 16'hFFFF));
    offer(op_item(FUNC_ADD, 8'h3C, 16'h0001));
    // two timeouts in one tick, then one more
    offer(op_item(FUNC_TICK,   8'hFF, 16'hFFFF));
    offer(op_item(FUNC_TICK,   8'h00, 16'h0000));
    offer(op_item(FUNC_REMOVE, 8'h00, 16'h0000));
    offer(op_item(FUNC_CLEAR,  8'hFF, 16'hFFFF));
    offer(op_item(FUNC_ADD, 8'h81, 16'h8000));
    offer(op_item(FUNC_ADD, 8'h7E, 16'h7FFF));
    offer(op_item(FUNC_TICK,   8'h55, 16'h5555));
    offer(op_item(FUNC_CLEAR,  8'hAA, 16'hAAAA));
    offer(op_item(FUNC_REMOVE, 8'h01, 16'h0001));

    random_phase = 1'b1;
    // fill past capacity first so full adds are reached
    repeat (QUEUE_DEPTH + 3) offer(random_op(MODE_FILL));
    while (n_sent < N_RANDOM + 17) begin
      mode = $urandom_range(MODE_GROW, MODE_MIX);
      seg  = $urandom_range(8, 30);
      repeat (seg) offer(random_op(mode));
    end
    in_valid <= 1'b0;

    while (sb.due.size() != 0) @(posedge clk);
    repeat (QUEUE_DEPTH + 4) @(posedge clk);

    $display("Sent %0d items: %0d adds, %0d removes, %0d ticks, %0d clears; peak depth %0d.",
             n_sent, sb.n_func[FUNC_ADD], sb.n_func[FUNC_REMOVE], sb.n_func[FUNC_TICK],
             sb.n_func[FUNC_CLEAR], sb.peak);
    $display("Released %0d dequeued, %0d timed out, %0d flushed; %0d full adds, %0d %s",
             sb.n_deq, sb.n_timeout, sb.n_flush, sb.n_full, sb.n_empty,
             "empty removes.");
    if (sb.errors == 0) begin
      $display("timed_wait_queue_core: match");
    end else begin
      $display("timed_wait_queue_core: mismatch");
    end
    $finish;
  end
endmodule
